/* hw/rtl/rvm_pkg.sv */
package rvm_pkg;

    // cursor format
    localparam int FRAC_BITS = 16;
    localparam int CUR_W     = 32;
    localparam int IDX_W     = CUR_W - FRAC_BITS;

    // request kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;
    localparam logic [1:0] KIND_FRAME = 2'd3;

    // configuration register indexes
    localparam logic CFG_GLOBAL   = 1'b0;
    localparam logic CFG_CATEGORY = 1'b1;

    localparam logic [15:0] VOL_RESET = 16'd32768;

    // reply kinds
    localparam logic REPLY_FRAME = 1'b0;
    localparam logic REPLY_START = 1'b1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        mem_address;
        logic signed [15:0] mem_sample;
        logic [15:0]        sound_base;
        logic [16:0]        sound_length;
        logic               stereo;
        logic [18:0]        pitch_ratio;
        logic [3:0]         voice_slot;
        logic signed [15:0] mix_in_left;
        logic signed [15:0] mix_in_right;
    } req_t;

    typedef struct packed {
        logic               reply_kind;
        logic signed [15:0] left_mix;
        logic signed [15:0] right_mix;
        logic [3:0]         slot_given;
        logic               start_ok;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic       accept;
        logic       mem_write;
        logic       stop;
        logic       frame_init;
        logic       voice_load;
        logic       tgt_load;
        logic       rd_step;
        logic       lerp_step;
        logic       scale_step;
        logic       voice_commit;
        logic       next_voice;
        logic       reply_load;
        logic [3:0] step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       voice_on;
        logic       last_voice;
        logic       rsp_free;
    } stat_t;

endpackage

/* hw/rtl/resampling_voice_mixer.sv */
// Resampling voice mixer.
// Request channel (req_valid / req_stall / req) takes one beat per request:
// write a sample word, start a voice, stop a voice, or render a stereo frame.
// Response channel (rsp_valid / rsp_stall / rsp) carries one beat for a start
// and for a frame; writes and stops answer nothing.
// Gains are written on cfg_we / cfg_index / cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce.
// One request is worked at a time. Each active voice in a frame needs eight
// reads on the single sample-memory port, four interpolations and two gain
// products on shared multipliers.
// The response sits in an output register; a stalled receiver holds it and
// the next request is still taken, but its response waits until the register
// frees up.
// Reset marks every voice inactive and sets both gains to unity; the sample
// memory keeps no reset and must be written before it is read.
module resampling_voice_mixer import rvm_pkg::*; #(
    parameter int VOICES    = 16,
    parameter int MEM_WORDS = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    rvm_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    rvm_datapath #(
        .VOICES    (VOICES),
        .MEM_WORDS (MEM_WORDS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

/* hw/rtl/rvm_datapath.sv */
module rvm_datapath import rvm_pkg::*; #(
    parameter int VOICES    = 16,
    parameter int MEM_WORDS = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  req_t        req,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  cmd_t        cmd,
    output stat_t       stat,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp
);

    localparam int VIW  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW   = $clog2(MEM_WORDS);
    localparam int SUMW = (AW > 18) ? AW : 18;

    req_t               item_reg;
    logic [15:0]        gvol_reg, cvol_reg;
    logic [31:0]        vol_reg;
    logic [VOICES-1:0]  active_reg;
    logic [15:0]        v_base   [VOICES];
    logic [16:0]        v_len    [VOICES];
    logic               v_stereo [VOICES];
    logic [18:0]        v_step   [VOICES];
    logic [CUR_W-1:0]   v_cursor [VOICES];
    logic [VIW-1:0]     vc_reg;
    logic [15:0]        base_reg;
    logic [16:0]        len_reg;
    logic               stereo_reg;
    logic [CUR_W-1:0]   cur_reg, tgt_reg;
    logic [CUR_W:0]     sum_reg, lenq_reg;
    logic signed [15:0] mem [MEM_WORDS];
    logic signed [15:0] rd_data_reg;
    logic signed [15:0] samp_reg [8];
    logic signed [34:0] prod_reg;
    logic signed [15:0] ahold_reg;
    logic signed [16:0] lerp_reg [4];
    logic signed [49:0] mprod_reg;
    logic [15:0]        accl_reg, accr_reg;
    rsp_t               rsp_reg;
    logic               rsp_valid_reg;

    // request hold
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= req;
        end
    end

    // gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gvol_reg <= VOL_RESET;
            cvol_reg <= VOL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GLOBAL:   gvol_reg <= cfg_data;
                CFG_CATEGORY: cvol_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // lowest free slot
    logic           found;
    logic [VIW-1:0] free_idx;
    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = 0; i < VOICES; i++)
        begin
            if (!found && !active_reg[i])
            begin
                found    = 1'b1;
                free_idx = VIW'(i);
            end
        end
    end

    logic do_start;
    assign do_start = cmd.reply_load && (item_reg.kind == KIND_START);

    // end-of-sound test on the new cursor
    logic signed [17:0] len_m;
    logic signed [33:0] thr;
    logic               voice_end;
    assign len_m     = $signed({1'b0, len_reg}) - (stereo_reg ? 18'sd3 : 18'sd2);
    assign thr       = {len_m, 16'b0};
    assign voice_end = $signed({2'b00, tgt_reg}) >= thr;

    // active bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else
        begin
            if (do_start && found)
            begin
                active_reg[free_idx] <= 1'b1;
            end
            if (cmd.stop)
            begin
                for (int i = 0; i < VOICES; i++)
                begin
                    if (i < 16 && item_reg.voice_slot == 4'(i))
                    begin
                        active_reg[i] <= 1'b0;
                    end
                end
            end
            if (cmd.voice_commit && voice_end)
            begin
                active_reg[vc_reg] <= 1'b0;
            end
        end
    end

    // voice table
    always_ff @(posedge clk)
    begin
        if (do_start && found)
        begin
            v_base[free_idx]   <= item_reg.sound_base;
            v_len[free_idx]    <= item_reg.sound_length;
            v_stereo[free_idx] <= item_reg.stereo;
            v_step[free_idx]   <= item_reg.pitch_ratio;
            v_cursor[free_idx] <= '0;
        end
        if (cmd.voice_commit)
        begin
            v_cursor[vc_reg] <= tgt_reg;
        end
    end

    // voice counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= '0;
        end
        else if (cmd.frame_init)
        begin
            vc_reg <= '0;
        end
        else if (cmd.next_voice)
        begin
            vc_reg <= (vc_reg == VIW'(VOICES - 1)) ? '0 : vc_reg + 1'b1;
        end
    end

    // voice load and cursor advance
    logic [CUR_W:0] tgt_wrap;
    assign tgt_wrap = (sum_reg >= lenq_reg) ? sum_reg - lenq_reg : sum_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.voice_load)
        begin
            base_reg   <= v_base[vc_reg];
            len_reg    <= v_len[vc_reg];
            stereo_reg <= v_stereo[vc_reg];
            cur_reg    <= v_cursor[vc_reg];
            sum_reg    <= {1'b0, v_cursor[vc_reg]} + (v_stereo[vc_reg] ?
                          (CUR_W+1)'({v_step[vc_reg], 1'b0}) : (CUR_W+1)'(v_step[vc_reg]));
            lenq_reg   <= (CUR_W+1)'({v_len[vc_reg], 16'b0});
        end
        if (cmd.tgt_load)
        begin
            tgt_reg <= tgt_wrap[CUR_W-1:0];
        end
    end

    // read address: taps 0..3 at old cursor, 4..7 at new
    logic [CUR_W-1:0] cpick;
    logic [IDX_W-1:0] idx;
    logic [1:0]       off;
    logic [SUMW-1:0]  addr_sum, wsum;
    logic [AW-1:0]    rd_addr, wr_addr;
    always_comb
    begin
        cpick = cmd.step[2] ? tgt_reg : cur_reg;
        idx   = cpick[CUR_W-1:FRAC_BITS];
        if (stereo_reg)
        begin
            idx[0] = 1'b0;
        end
        case (cmd.step[1:0])
            2'd0:    off = 2'd0;
            2'd1:    off = stereo_reg ? 2'd2 : 2'd1;
            2'd2:    off = stereo_reg ? 2'd1 : 2'd0;
            default: off = stereo_reg ? 2'd3 : 2'd1;
        endcase
        addr_sum = SUMW'(base_reg) + SUMW'(idx) + SUMW'(off);
        rd_addr  = addr_sum[AW-1:0];
        wsum     = SUMW'(item_reg.mem_address);
        wr_addr  = wsum[AW-1:0];
    end

    // sample memory
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            mem[wr_addr] <= item_reg.mem_sample;
        end
        if (cmd.rd_step && !cmd.step[3])
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // capture the registered read data into the tap of the step count less one
    logic [3:0] cap_idx;
    assign cap_idx = cmd.step - 4'd1;
    always_ff @(posedge clk)
    begin
        if (cmd.rd_step && cmd.step != 4'd0)
        begin
            samp_reg[cap_idx[2:0]] <= rd_data_reg;
        end
    end

    // interpolation: even step multiplies, odd step rounds toward zero
    logic [1:0]         lj;
    logic signed [15:0] la, lb;
    logic [16:0]        lf;
    logic signed [16:0] ldiff;
    logic signed [36:0] ln, ladj, lsh;
    always_comb
    begin
        lj    = cmd.step[2:1];
        la    = samp_reg[{lj, 1'b0}];
        lb    = samp_reg[{lj, 1'b1}];
        if (lj[1])
        begin
            lf = stereo_reg ? tgt_reg[16:0] : {1'b0, tgt_reg[15:0]};
        end
        else
        begin
            lf = stereo_reg ? cur_reg[16:0] : {1'b0, cur_reg[15:0]};
        end
        ldiff = 17'(lb) - 17'(la);
        ln    = (37'(ahold_reg) <<< (stereo_reg ? 17 : 16)) + 37'(prod_reg);
        ladj  = ln;
        if (ln < 0)
        begin
            ladj = ln + (stereo_reg ? 37'sd131071 : 37'sd65535);
        end
        lsh   = stereo_reg ? (ladj >>> 17) : (ladj >>> 16);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lerp_step)
        begin
            if (!cmd.step[0])
            begin
                prod_reg  <= 35'(ldiff) * 35'($signed({1'b0, lf}));
                ahold_reg <= la;
            end
            else
            begin
                lerp_reg[lj] <= lsh[16:0];
            end
        end
    end

    // average, gain, accumulate
    logic               sc;
    logic signed [17:0] ssum;
    logic signed [17:0] savg;
    logic signed [49:0] madj;
    always_comb
    begin
        sc   = cmd.step[1];
        ssum = 18'(lerp_reg[{1'b0, sc}]) + 18'(lerp_reg[{1'b1, sc}]);
        savg = (ssum + ((ssum < 0) ? 18'sd1 : 18'sd0)) >>> 1;
        madj = mprod_reg + ((mprod_reg < 0) ? 50'sd1073741823 : 50'sd0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.frame_init)
        begin
            accl_reg <= item_reg.mix_in_left;
            accr_reg <= item_reg.mix_in_right;
            vol_reg  <= 32'(gvol_reg) * 32'(cvol_reg);
        end
        if (cmd.scale_step)
        begin
            if (!cmd.step[0])
            begin
                mprod_reg <= 50'(savg) * 50'($signed({1'b0, vol_reg}));
            end
            else if (!sc)
            begin
                accl_reg <= accl_reg + madj[45:30];
            end
            else
            begin
                accr_reg <= accr_reg + madj[45:30];
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.reply_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.reply_load)
        begin
            if (item_reg.kind == KIND_START)
            begin
                rsp_reg.reply_kind <= REPLY_START;
                rsp_reg.left_mix   <= '0;
                rsp_reg.right_mix  <= '0;
                rsp_reg.slot_given <= found ? 4'(free_idx) : 4'd0;
                rsp_reg.start_ok   <= found;
            end
            else
            begin
                rsp_reg.reply_kind <= REPLY_FRAME;
                rsp_reg.left_mix   <= accl_reg;
                rsp_reg.right_mix  <= accr_reg;
                rsp_reg.slot_given <= 4'd0;
                rsp_reg.start_ok   <= 1'b0;
            end
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign rsp             = rsp_reg;
    assign stat.kind       = item_reg.kind;
    assign stat.voice_on   = active_reg[vc_reg];
    assign stat.last_voice = (vc_reg == VIW'(VOICES - 1));
    assign stat.rsp_free   = !rsp_valid_reg || !rsp_stall;

endmodule

/* hw/rtl/rvm_control.sv */
module rvm_control import rvm_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_EXEC    = 9'b000000010,
        S_REPLY   = 9'b000000100,
        S_VLOAD   = 9'b000001000,
        S_VTGT    = 9'b000010000,
        S_VREAD   = 9'b000100000,
        S_VLERP   = 9'b001000000,
        S_VSCALE  = 9'b010000000,
        S_VCOMMIT = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        req_stall  = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.kind)
                    KIND_WRITE:
                    begin
                        cmd.mem_write = 1'b1;
                        state_next    = S_IDLE;
                    end
                    KIND_STOP:
                    begin
                        cmd.stop   = 1'b1;
                        state_next = S_IDLE;
                    end
                    KIND_START:
                    begin
                        state_next = S_REPLY;
                    end
                    default:
                    begin
                        cmd.frame_init = 1'b1;
                        state_next     = S_VLOAD;
                    end
                endcase
            end
            S_VLOAD:
            begin
                if (stat.voice_on)
                begin
                    cmd.voice_load = 1'b1;
                    state_next     = S_VTGT;
                end
                else
                begin
                    cmd.next_voice = 1'b1;
                    if (stat.last_voice)
                    begin
                        state_next = S_REPLY;
                    end
                end
            end
            S_VTGT:
            begin
                cmd.tgt_load = 1'b1;
                step_next    = 4'd0;
                state_next   = S_VREAD;
            end
            S_VREAD:
            begin
                cmd.rd_step = 1'b1;
                if (step_reg == 4'd8)
                begin
                    step_next  = 4'd0;
                    state_next = S_VLERP;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_VLERP:
            begin
                cmd.lerp_step = 1'b1;
                if (step_reg == 4'd7)
                begin
                    step_next  = 4'd0;
                    state_next = S_VSCALE;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_VSCALE:
            begin
                cmd.scale_step = 1'b1;
                if (step_reg == 4'd3)
                begin
                    step_next  = 4'd0;
                    state_next = S_VCOMMIT;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_VCOMMIT:
            begin
                cmd.voice_commit = 1'b1;
                cmd.next_voice   = 1'b1;
                state_next       = stat.last_voice ? S_REPLY : S_VLOAD;
            end
            S_REPLY:
            begin
                if (stat.rsp_free)
                begin
                    cmd.reply_load = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // checks
    a_reply_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.reply_load |-> stat.rsp_free)
        else $error("reply loaded into a full output register");

    a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_write || cmd.stop || cmd.frame_init) |-> $past(cmd.accept))
        else $error("request executed without a fresh beat");

    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_step |-> (cmd.step <= 4'd8))
        else $error("read sequencer step out of range");

endmodule

/* tb/tb_resampling_voice_mixer.sv */
module tb_resampling_voice_mixer;
    import rvm_pkg::*;

    localparam int NVOICE   = 16;
    localparam int DRAIN_CY = 450;

    // Voice table and sample memory predictor with the queue of pending replies
    class mix_scoreboard;
        logic [15:0] gain_master;
        logic [15:0] gain_cat;
        bit          on      [NVOICE];
        logic [15:0] base    [NVOICE];
        logic [16:0] len     [NVOICE];
        bit          two_ch  [NVOICE];
        logic [18:0] step    [NVOICE];
        longint      cursor  [NVOICE];
        logic [15:0] mem     [65536];
        rsp_t        pending [$];
        int          errors;
        int          frames;
        int          starts;
        int          full_starts;

        function new();
            gain_master = VOL_RESET;
            gain_cat    = VOL_RESET;
            for (int v = 0; v < NVOICE; v++)
            begin
                on[v] = 0; base[v] = '0; len[v] = '0; two_ch[v] = 0;
                step[v] = '0; cursor[v] = 0;
            end
            errors = 0; frames = 0; starts = 0; full_starts = 0;
        endfunction

        function void set_gain(logic idx, logic [15:0] val);
            if (idx == CFG_GLOBAL)
                gain_master = val;
            else
                gain_cat = val;
        endfunction

        function longint word_at(int v, longint idx);
            logic [15:0] a;
            a = 16'(longint'(base[v]) + idx);
            return longint'($signed(mem[a]));
        endfunction

        function longint interp(longint a, longint b, longint f, int fb);
            longint d;
            d = longint'(1) << fb;
            return (a * d + (b - a) * f) / d;
        endfunction

        // interpolated left and right value of voice v at cursor c
        function void pick(int v, longint c, output longint l, output longint r);
            longint ch;
            longint idx;
            longint f;
            int     fb;
            ch  = two_ch[v] ? 2 : 1;
            fb  = FRAC_BITS + int'(ch) - 1;
            idx = c >>> FRAC_BITS;
            f   = c & ((longint'(1) << fb) - 1);
            if (ch == 2)
                idx = idx & ~longint'(1);
            l = interp(word_at(v, idx), word_at(v, idx + ch), f, fb);
            r = interp(word_at(v, idx + ch - 1), word_at(v, idx + 2 * ch - 1), f, fb);
        endfunction

        function logic [15:0] gained(longint s, longint t);
            longint avg;
            longint vol;
            longint q;
            avg = (s + t) / 2;
            vol = longint'(gain_master) * longint'(gain_cat);
            q   = (avg * vol) / (longint'(1) << 30);
            return q[15:0];
        endfunction

        // accepted request beat: update state, queue any reply
        function void note(req_t r);
            rsp_t        e;
            logic [15:0] accl;
            logic [15:0] accr;
            longint      ch, tgt, lenq, thr, sl, sr, tl, tr;
            e = '0;
            case (r.kind)
                KIND_WRITE: mem[r.mem_address] = r.mem_sample;
                KIND_STOP:  on[r.voice_slot] = 0;
                KIND_START:
                begin
                    e.reply_kind = REPLY_START;
                    starts++;
                    for (int v = 0; v < NVOICE; v++)
                    begin
                        if (!on[v] && !e.start_ok)
                        begin
                            on[v] = 1; base[v] = r.sound_base; len[v] = r.sound_length;
                            two_ch[v] = r.stereo; step[v] = r.pitch_ratio; cursor[v] = 0;
                            e.slot_given = 4'(v);
                            e.start_ok = 1;
                        end
                    end
                    if (!e.start_ok)
                        full_starts++;
                    pending.push_back(e);
                end
                default:
                begin
                    accl = r.mix_in_left;
                    accr = r.mix_in_right;
                    frames++;
                    for (int v = 0; v < NVOICE; v++)
                    begin
                        if (on[v])
                        begin
                            ch   = two_ch[v] ? 2 : 1;
                            lenq = longint'(len[v]) << FRAC_BITS;
                            tgt  = cursor[v] + ch * longint'(step[v]);
                            if (tgt >= lenq)
                                tgt = tgt - lenq;
                            tgt = tgt & 64'hFFFF_FFFF;
                            pick(v, cursor[v], sl, sr);
                            pick(v, tgt, tl, tr);
                            accl = accl + gained(sl, tl);
                            accr = accr + gained(sr, tr);
                            cursor[v] = tgt;
                            thr = (longint'(len[v]) - ch - 1) * (longint'(1) << FRAC_BITS);
                            if (tgt >= thr)
                                on[v] = 0;
                        end
                    end
                    e.reply_kind = REPLY_FRAME;
                    e.left_mix   = accl;
                    e.right_mix  = accr;
                    pending.push_back(e);
                end
            endcase
        endfunction

        // accepted response beat against the oldest expectation
        function void check(rsp_t a);
            rsp_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected response beat %h", a);
                return;
            end
            e = pending.pop_front();
            if (a.reply_kind !== e.reply_kind || a.left_mix !== e.left_mix ||
                a.right_mix !== e.right_mix || a.slot_given !== e.slot_given ||
                a.start_ok !== e.start_ok)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp kind %0d L %0d R %0d slot %0d ok %0d",
                              " / got kind %0d L %0d R %0d slot %0d ok %0d"},
                             e.reply_kind, e.left_mix, e.right_mix, e.slot_given,
                             e.start_ok, a.reply_kind, a.left_mix, a.right_mix,
                             a.slot_given, a.start_ok);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    mix_scoreboard sb;
    bit            hold_go;
    int            hold_cnt;
    int            longest_hold;

    resampling_voice_mixer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // offer one request beat and wait for it to be taken
    task automatic send(input req_t r);
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (req_stall);
        sb.note(r);
    endtask

    task automatic pause(input int n);
        req_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // wait until all replies arrived, then let a slow frame finish
    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CY) @(posedge clk);
    endtask

    task automatic write_gain(input logic idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_gain(idx, val);
    endtask

    function automatic req_t noise();
        req_t         r;
        logic [159:0] rnd;
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
        r   = rnd[$bits(req_t)-1:0];
        r.sound_length = 17'($urandom_range(0, 65536));
        return r;
    endfunction

    function automatic req_t start_req(logic [15:0] b, int n, logic st, logic [18:0] p);
        req_t r;
        r = noise();
        r.kind = KIND_START; r.sound_base = b; r.sound_length = 17'(n);
        r.stereo = st; r.pitch_ratio = p;
        return r;
    endfunction

    function automatic req_t frame_req(logic [15:0] l, logic [15:0] rr);
        req_t r;
        r = noise();
        r.kind = KIND_FRAME; r.mix_in_left = l; r.mix_in_right = rr;
        return r;
    endfunction

    // random item; long_voices keeps sounds long so the table fills up.
    // Sounds start near address zero and stay short or slow, so every read
    // lands in the written window.
    function automatic req_t rand_req(bit long_voices);
        req_t r;
        int   pick;
        int   lsel;
        r    = noise();
        pick = $urandom_range(0, 99);
        if (pick < 45)
            r.kind = KIND_FRAME;
        else if (pick < 72)
        begin
            r.kind = KIND_START;
            r.sound_base = 16'($urandom_range(0, 95)) - 16'd32;
            lsel = $urandom_range(0, 9);
            if ($urandom_range(0, 3) != 0)
                r.pitch_ratio = 19'($urandom_range(0, 200000));
            if (long_voices)
            begin
                r.sound_length = 17'($urandom_range(120, 220));
                r.pitch_ratio  = 19'($urandom_range(0, 4096));
            end
            else if (lsel < 9)
                r.sound_length = 17'($urandom_range(0, 220));
            else if ($urandom_range(0, 1) != 0)
            begin
                r.sound_length = 17'd65536;
                r.pitch_ratio  = 19'($urandom_range(0, 512));
            end
            else
                r.sound_length = 17'd0;
        end
        else if (pick < 87)
            r.kind = KIND_STOP;
        else
            r.kind = KIND_WRITE;
        return r;
    endfunction

    // receiver: stall pattern plus one long hold-off on request
    initial
    begin
        int mode;
        int left;
        bit held;
        rsp_stall = 1'b0;
        mode = 0; left = 0; hold_cnt = 0; longest_hold = 0; held = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                sb.check(rsp);
            if (hold_go && !held)
            begin
                held     = 1;
                hold_cnt = 1200;
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(8, 120);
            end
            left--;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                longest_hold++;
                rsp_stall <= 1'b1;
            end
            else if (mode == 0)
                rsp_stall <= 1'b0;
            else if (mode == 1)
                rsp_stall <= ($urandom_range(0, 1) == 0);
            else if (mode == 2)
                rsp_stall <= ($urandom_range(0, 9) != 0);
            else
                rsp_stall <= ($urandom_range(0, 9) == 0);
        end
    end

    // stimulus
    initial
    begin
        req_t        r;
        int          burst;
        int          count;
        logic [15:0] gm [5];
        logic [15:0] gc [5];
        sb        = new();
        hold_go   = 0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_GLOBAL;
        cfg_data  = VOL_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // write a window across the top of memory and around address zero;
        // every sound below reads only inside it
        for (int a = -32; a < 320; a++)
        begin
            r = noise();
            r.kind = KIND_WRITE;
            r.mem_address = 16'(a);
            if (a == 0)
                r.mem_sample = 16'sh7FFF;
            else if (a == 1)
                r.mem_sample = 16'sh8000;
            send(r);
        end

        // directed: extremes and short sounds at reset gains
        send(frame_req(16'h7FFF, 16'h8000));
        send(start_req(16'd0, 0, 1'b0, 19'h10000));
        send(start_req(16'hFFFF, 1, 1'b1, 19'h7FFFF));
        send(start_req(16'hFFF0, 65536, 1'b1, 19'h7FFFF));
        send(start_req(16'd200, 65536, 1'b0, 19'd0));
        send(start_req(16'd100, 3, 1'b0, 19'h08000));
        send(frame_req(16'h8000, 16'h7FFF));
        send(frame_req(16'h0000, 16'hFFFF));
        r = noise(); r.kind = KIND_STOP; r.voice_slot = 4'd15;
        send(r);
        r = noise(); r.kind = KIND_STOP; r.voice_slot = 4'd2;
        send(r);
        send(frame_req(16'h7FFF, 16'h7FFF));
        r = noise(); r.kind = KIND_WRITE; r.mem_address = 16'hFFFF; r.mem_sample = 16'sh8000;
        send(r);
        send(start_req(16'hFFFF, 200, 1'b1, 19'h18000));
        send(frame_req(16'h0000, 16'h0000));
        send(frame_req(16'h0000, 16'h0000));
        drain();

        // gain settings per phase, extremes included
        gm[0] = VOL_RESET; gc[0] = VOL_RESET;
        gm[1] = 16'hFFFF;  gc[1] = 16'hFFFF;
        gm[2] = 16'h0000;  gc[2] = 16'hFFFF;
        gm[3] = 16'hFFFF;  gc[3] = 16'h0000;
        gm[4] = 16'($urandom); gc[4] = 16'($urandom);

        for (int ph = 0; ph < 5; ph++)
        begin
            write_gain(CFG_GLOBAL, gm[ph]);
            write_gain(CFG_CATEGORY, gc[ph]);
            count = 0;
            while (count < 100)
            begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst && count < 100; k++)
                begin
                    if (ph == 1 && count == 40)
                        hold_go = 1;
                    send(rand_req(ph == 1 && count < 60));
                    count++;
                end
                if ($urandom_range(0, 2) != 0)
                    pause($urandom_range(1, 40));
            end
            drain();
        end

        $display("covered %0d frames, %0d starts (%0d with no free slot), five gain settings",
                 sb.frames, sb.starts, sb.full_starts);
        $display("receiver held off %0d cycles in one stretch; mismatches: %0d",
                 longest_hold, sb.errors);
        if (sb.errors == 0)
            $display("tb_resampling_voice_mixer: PASS");
        else
            $display("tb_resampling_voice_mixer: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #60000000;
        $display("tb_resampling_voice_mixer: FAIL");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/rvm_pkg.sv
hw/rtl/rvm_datapath.sv
hw/rtl/rvm_control.sv
hw/rtl/resampling_voice_mixer.sv
tb/tb_resampling_voice_mixer.sv
